@@ sv/edbp_pkg.sv @@
// Shared types, constants and helpers for the EDID base block parser.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none

package edbp_pkg;

   // Block layout
   localparam logic [7:0] BLOCK_BYTES   = 8'd128;
   localparam logic [7:0] HEADER_BYTES  = 8'd8;
   localparam logic [7:0] VENDOR_HI_POS = 8'd8;
   localparam logic [7:0] VENDOR_LO_POS = 8'd9;
   localparam logic [7:0] ID_END        = 8'd10;
   localparam logic [7:0] DESC_START    = 8'd54;
   localparam logic [7:0] DESC_END      = 8'd126;  // four descriptors of 18 bytes
   localparam logic [7:0] EXT_POS       = 8'd126;

   // Offsets inside one 18-byte descriptor
   localparam logic [4:0] OFF_FIRST = 5'd0;
   localparam logic [4:0] OFF_ZERO1 = 5'd1;
   localparam logic [4:0] OFF_ZERO2 = 5'd2;
   localparam logic [4:0] OFF_KIND  = 5'd3;
   localparam logic [4:0] OFF_ZERO4 = 5'd4;
   localparam logic [4:0] OFF_TEXT  = 5'd5;
   localparam logic [4:0] OFF_LAST  = 5'd17;

   // Descriptor tags
   localparam logic [7:0] KIND_NAME   = 8'hFC;
   localparam logic [7:0] KIND_SERIAL = 8'hFF;
   localparam logic [7:0] KIND_TEXT   = 8'hFE;

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_LOW     = 8'h20;
   localparam logic [7:0] CHAR_HIGH    = 8'h7E;

   localparam int NAME_CHARS  = 13;
   localparam int KEPT_SLOTS  = 3;
   localparam int QUEUE_DEPTH = 2;

   // Status codes
   localparam logic [2:0] STATUS_OK             = 3'd0;
   localparam logic [2:0] STATUS_BAD_HEADER     = 3'd1;
   localparam logic [2:0] STATUS_ID_TRUNCATED   = 3'd2;
   localparam logic [2:0] STATUS_BAD_PNP        = 3'd3;
   localparam logic [2:0] STATUS_NO_DESCRIPTORS = 3'd4;
   localparam logic [2:0] STATUS_NO_NAME        = 3'd5;

   // Name sources, also the kept-text slot numbers
   localparam logic [1:0] SRC_DISPLAY = 2'd0;
   localparam logic [1:0] SRC_SERIAL  = 2'd1;
   localparam logic [1:0] SRC_TEXT    = 2'd2;

   typedef logic [NAME_CHARS-1:0][6:0] name_text_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] manufacturer_id;
      logic [6:0]  letter_first;
      logic [6:0]  letter_second;
      logic [6:0]  letter_third;
      logic [6:0]  name_char;
      logic [3:0]  name_length;
      logic [1:0]  name_source;
      logic        checksum_ok;
      logic        extension_present;
      logic        is_truncated;
      logic        last_of_run;
   } rsp_type;

   // Everything the back end needs to play out one block's results
   typedef struct packed {
      logic [2:0]    status;
      logic [15:0]   manufacturer_id;
      logic [6:0]    letter_first;
      logic [6:0]    letter_second;
      logic [6:0]    letter_third;
      logic [3:0]    name_length;
      logic [1:0]    name_source;
      logic          has_name;
      logic          checksum_ok;
      logic          extension_present;
      logic          is_truncated;
      name_text_type name_text;
   } summary_type;

   typedef struct packed {
      logic not_empty;
      logic not_full;
   } queue_status_type;

   // Magic header is 00 FF FF FF FF FF FF 00
   function automatic logic [7:0] magic_byte(input logic [2:0] idx);
      logic [7:0] val;
      val = (idx == 3'd0 || idx == 3'd7) ? 8'h00 : 8'hFF;
      return val;
   endfunction

   // Five-bit compressed letter, 1..26 maps to A..Z, anything else is 0
   function automatic logic [6:0] pnp_letter(input logic [4:0] code);
      logic [6:0] val;
      val = (code >= 5'd1 && code <= 5'd26) ? (7'd64 + {2'b00, code}) : 7'd0;
      return val;
   endfunction

endpackage

`default_nettype wire

@@ sv/edbp_front.sv @@
// Front end: takes bytes, tracks header, checksum, vendor ID and descriptors,
// and builds a run summary on the final byte. Depends on edbp_pkg.
`default_nettype none

module edbp_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  byte_fire,
   input  wire edbp_pkg::req_type     byte_in,
   output logic                       push,
   output edbp_pkg::summary_type      summary
);

   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  sum_ff, sum_in;
   logic        hdr_ok_ff, hdr_ok_in;
   logic [15:0] vendor_ff, vendor_in;
   logic        ext_ff, ext_in;
   logic        dh_ok_ff, dh_ok_in;
   logic [7:0]  kind_ff, kind_in;
   logic [4:0]  off_ff, off_in;
   logic [3:0]  scr_len_ff, scr_len_in;
   logic        scr_print_ff, scr_print_in;
   logic        scr_nl_ff, scr_nl_in;
   logic [3:0]  kept_len_ff [edbp_pkg::KEPT_SLOTS];
   logic [3:0]  kept_len_in [edbp_pkg::KEPT_SLOTS];

   edbp_pkg::name_text_type scr_text_ff, scr_text_in;
   edbp_pkg::name_text_type kept_text_ff [edbp_pkg::KEPT_SLOTS];
   edbp_pkg::name_text_type kept_text_in [edbp_pkg::KEPT_SLOTS];

   logic [7:0]  b;
   logic [3:0]  text_idx;
   logic        slot_hit;
   logic [1:0]  slot;
   logic [6:0]  l0, l1, l2;
   logic [2:0]  st;
   logic [1:0]  src;
   logic        src_found;

   assign b        = byte_in.data_byte;
   assign text_idx = 4'(off_ff - edbp_pkg::OFF_TEXT);
   assign push     = byte_fire && byte_in.final_byte;

   always_comb begin
      pos_in       = pos_ff;
      sum_in       = sum_ff;
      hdr_ok_in    = hdr_ok_ff;
      vendor_in    = vendor_ff;
      ext_in       = ext_ff;
      dh_ok_in     = dh_ok_ff;
      kind_in      = kind_ff;
      off_in       = off_ff;
      scr_len_in   = scr_len_ff;
      scr_print_in = scr_print_ff;
      scr_nl_in    = scr_nl_ff;
      scr_text_in  = scr_text_ff;
      kept_len_in  = kept_len_ff;
      kept_text_in = kept_text_ff;
      slot_hit     = 1'b0;
      slot         = edbp_pkg::SRC_DISPLAY;

      unique case (kind_ff)
         edbp_pkg::KIND_NAME: begin
            slot_hit = 1'b1;
            slot     = edbp_pkg::SRC_DISPLAY;
         end
         edbp_pkg::KIND_SERIAL: begin
            slot_hit = 1'b1;
            slot     = edbp_pkg::SRC_SERIAL;
         end
         edbp_pkg::KIND_TEXT: begin
            slot_hit = 1'b1;
            slot     = edbp_pkg::SRC_TEXT;
         end
         default: begin
            slot_hit = 1'b0;
         end
      endcase

      // bytes beyond the block only matter for their final flag
      if (byte_fire && pos_ff < edbp_pkg::BLOCK_BYTES) begin
         pos_in = pos_ff + 8'd1;
         sum_in = sum_ff + b;
         if (pos_ff < edbp_pkg::HEADER_BYTES && b != edbp_pkg::magic_byte(pos_ff[2:0])) begin
            hdr_ok_in = 1'b0;
         end
         if (pos_ff == edbp_pkg::VENDOR_HI_POS) begin
            vendor_in[15:8] = b;
         end
         if (pos_ff == edbp_pkg::VENDOR_LO_POS) begin
            vendor_in[7:0] = b;
         end
         if (pos_ff == edbp_pkg::EXT_POS) begin
            ext_in = (b != 8'd0);
         end
         if (pos_ff >= edbp_pkg::DESC_START && pos_ff < edbp_pkg::DESC_END) begin
            off_in = (off_ff == edbp_pkg::OFF_LAST) ? 5'd0 : off_ff + 5'd1;
            priority if (off_ff == edbp_pkg::OFF_FIRST) begin
               dh_ok_in     = (b == 8'd0);
               scr_len_in   = 4'd0;
               scr_print_in = 1'b1;
               scr_nl_in    = 1'b0;
            end else if (off_ff == edbp_pkg::OFF_ZERO1 || off_ff == edbp_pkg::OFF_ZERO2
                         || off_ff == edbp_pkg::OFF_ZERO4) begin
               if (b != 8'd0) begin
                  dh_ok_in = 1'b0;
               end
            end else if (off_ff == edbp_pkg::OFF_KIND) begin
               kind_in = b;
            end else begin
               scr_text_in[text_idx] = b[6:0];
               if (!scr_nl_ff) begin
                  if (b == edbp_pkg::CHAR_NEWLINE) begin
                     scr_nl_in = 1'b1;
                  end else begin
                     if (b < edbp_pkg::CHAR_LOW || b > edbp_pkg::CHAR_HIGH) begin
                        scr_print_in = 1'b0;
                     end
                     scr_len_in = scr_len_ff + 4'd1;
                  end
               end
               // descriptor complete: keep its text in the slot for its tag
               if (off_ff == edbp_pkg::OFF_LAST && dh_ok_ff && slot_hit) begin
                  kept_text_in[slot] = scr_text_in;
                  kept_len_in[slot]  = scr_print_in ? scr_len_in : 4'd0;
               end
            end
         end
      end
   end

   // Summary of the block as it stands after this byte
   assign l0 = edbp_pkg::pnp_letter(vendor_in[14:10]);
   assign l1 = edbp_pkg::pnp_letter(vendor_in[9:5]);
   assign l2 = edbp_pkg::pnp_letter(vendor_in[4:0]);

   always_comb begin
      src       = edbp_pkg::SRC_DISPLAY;
      src_found = 1'b1;
      priority if (kept_len_in[edbp_pkg::SRC_DISPLAY] != 4'd0) begin
         src = edbp_pkg::SRC_DISPLAY;
      end else if (kept_len_in[edbp_pkg::SRC_SERIAL] != 4'd0) begin
         src = edbp_pkg::SRC_SERIAL;
      end else if (kept_len_in[edbp_pkg::SRC_TEXT] != 4'd0) begin
         src = edbp_pkg::SRC_TEXT;
      end else begin
         src_found = 1'b0;
      end

      priority if (pos_in < edbp_pkg::HEADER_BYTES || !hdr_ok_in) begin
         st = edbp_pkg::STATUS_BAD_HEADER;
      end else if (pos_in < edbp_pkg::ID_END) begin
         st = edbp_pkg::STATUS_ID_TRUNCATED;
      end else if (l0 == 7'd0 || l1 == 7'd0 || l2 == 7'd0) begin
         st = edbp_pkg::STATUS_BAD_PNP;
      end else if (pos_in < edbp_pkg::DESC_START) begin
         st = edbp_pkg::STATUS_NO_DESCRIPTORS;
      end else if (!src_found) begin
         st = edbp_pkg::STATUS_NO_NAME;
      end else begin
         st = edbp_pkg::STATUS_OK;
      end

      summary.status = st;
      summary.manufacturer_id = (st == edbp_pkg::STATUS_BAD_HEADER
                                 || st == edbp_pkg::STATUS_ID_TRUNCATED) ? 16'd0 : vendor_in;
      summary.has_name          = (st == edbp_pkg::STATUS_OK);
      summary.letter_first      = summary.has_name ? l0 : 7'd0;
      summary.letter_second     = summary.has_name ? l1 : 7'd0;
      summary.letter_third      = summary.has_name ? l2 : 7'd0;
      summary.name_length       = summary.has_name ? kept_len_in[src] : 4'd0;
      summary.name_source       = summary.has_name ? src : edbp_pkg::SRC_DISPLAY;
      summary.checksum_ok       = (pos_in >= edbp_pkg::BLOCK_BYTES) && (sum_in == 8'd0);
      summary.extension_present = ext_in;
      summary.is_truncated      = (pos_in < edbp_pkg::BLOCK_BYTES);
      summary.name_text         = kept_text_in[src];
   end

   // Control state: cleared by reset and again after each final byte
   always_ff @(posedge clock) begin
      if (reset || push) begin
         pos_ff       <= 8'd0;
         sum_ff       <= 8'd0;
         hdr_ok_ff    <= 1'b1;
         vendor_ff    <= 16'd0;
         ext_ff       <= 1'b0;
         dh_ok_ff     <= 1'b0;
         kind_ff      <= 8'd0;
         off_ff       <= 5'd0;
         scr_len_ff   <= 4'd0;
         scr_print_ff <= 1'b1;
         scr_nl_ff    <= 1'b0;
         for (int i = 0; i < edbp_pkg::KEPT_SLOTS; i++) begin
            kept_len_ff[i] <= 4'd0;
         end
      end else begin
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         hdr_ok_ff    <= hdr_ok_in;
         vendor_ff    <= vendor_in;
         ext_ff       <= ext_in;
         dh_ok_ff     <= dh_ok_in;
         kind_ff      <= kind_in;
         off_ff       <= off_in;
         scr_len_ff   <= scr_len_in;
         scr_print_ff <= scr_print_in;
         scr_nl_ff    <= scr_nl_in;
         kept_len_ff  <= kept_len_in;
      end
   end

   // Text stores: only read within a length set when written
   always_ff @(posedge clock) begin
      scr_text_ff  <= scr_text_in;
      kept_text_ff <= kept_text_in;
   end

endmodule

`default_nettype wire

@@ sv/edbp_queue.sv @@
// Small FIFO of run summaries between front and back end.
// Depends on edbp_pkg.
`default_nettype none

module edbp_queue #(
   parameter int Depth = edbp_pkg::QUEUE_DEPTH
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire edbp_pkg::summary_type  push_data,
   input  wire logic                   pop,
   output edbp_pkg::summary_type       head,
   output edbp_pkg::queue_status_type  stat
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   edbp_pkg::summary_type entries_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign stat.not_empty = (count_ff != CntW'(0));
   assign stat.not_full  = (count_ff != CntW'(Depth));
   assign do_push        = push && stat.not_full;
   assign do_pop         = pop && stat.not_empty;
   assign head           = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? PtrW'(0) : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? PtrW'(0) : rd_ptr_ff + PtrW'(1);
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CntW'(1);
         2'b01:   count_in = count_ff - CntW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ sv/edbp_back.sv @@
// Back end: plays a run summary out as one result per character, or one
// error result, into the output register. Depends on edbp_pkg.
`default_nettype none

module edbp_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire edbp_pkg::summary_type      head,
   input  wire edbp_pkg::queue_status_type stat,
   output logic                            pop,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output edbp_pkg::rsp_type               rsp_payload
);

   logic              rsp_valid_ff, rsp_valid_in;
   edbp_pkg::rsp_type rsp_ff, rsp_in;
   logic [3:0]        k_ff, k_in;
   logic [3:0]        run_len;
   logic              last;
   logic              can_load;

   assign run_len  = head.has_name ? head.name_length : 4'd1;
   assign last     = ((k_ff + 4'd1) == run_len);
   assign can_load = !rsp_valid_ff || rsp_ready;
   assign pop      = can_load && stat.not_empty && last;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      k_in         = k_ff;
      if (can_load) begin
         rsp_valid_in = stat.not_empty;
         if (stat.not_empty) begin
            rsp_in.status            = head.status;
            rsp_in.manufacturer_id   = head.manufacturer_id;
            rsp_in.letter_first      = head.letter_first;
            rsp_in.letter_second     = head.letter_second;
            rsp_in.letter_third      = head.letter_third;
            rsp_in.name_char         = head.has_name ? head.name_text[k_ff] : 7'd0;
            rsp_in.name_length       = head.name_length;
            rsp_in.name_source       = head.name_source;
            rsp_in.checksum_ok       = head.checksum_ok;
            rsp_in.extension_present = head.extension_present;
            rsp_in.is_truncated      = head.is_truncated;
            rsp_in.last_of_run       = last;
            k_in                     = last ? 4'd0 : k_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         k_ff         <= 4'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

@@ sv/edid_base_block_parser_core.sv @@
// Top level of the EDID base block parser: front end, summary queue, back end.
// Depends on edbp_pkg, edbp_front, edbp_queue and edbp_back.
//
// Bytes of an identification block come in one item per clock on the req_
// channel, final_byte set on the last one. The front end takes one byte each
// cycle: it checks the 8-byte magic header, sums bytes 0..127 for the
// checksum, keeps the big-endian manufacturer ID from bytes 8 and 9 and the
// extension flag from byte 126, and walks the four 18-byte descriptors from
// byte 54, keeping the 13-byte text of display name (FC), serial number (FF)
// and ASCII text (FE) descriptors, cut at the first newline and emptied if
// any character is not printable. Bytes past 128 only count for their final
// flag. On the final byte the whole outcome of the block is written as one
// summary into a queue of QueueDepth entries, and the front is clear for the
// next block in the very next cycle. The back end plays each summary out on
// the rsp_ channel: one item per character of the chosen name (display name,
// then serial number, then ASCII text), or a single error item; last_of_run
// marks the end of each run. Rate: one input byte per cycle; a run holds 1 to
// 13 result items. The input stalls only while the summary queue is full,
// i.e. when blocks end faster than the back end can drain their names. There
// is no configuration and no clearing pass.
`default_nettype none

module edid_base_block_parser_core #(
   parameter int QueueDepth = edbp_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire edbp_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output edbp_pkg::rsp_type      rsp_payload
);

   logic                       byte_fire;
   logic                       push;
   logic                       pop;
   edbp_pkg::summary_type      summary;
   edbp_pkg::summary_type      head;
   edbp_pkg::queue_status_type stat;

   // one free queue slot is all a final byte needs
   assign req_ready = stat.not_full;
   assign byte_fire = req_valid && req_ready;

   edbp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .byte_fire (byte_fire),
      .byte_in   (req_payload),
      .push      (push),
      .summary   (summary)
   );

   edbp_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (summary),
      .pop       (pop),
      .head      (head),
      .stat      (stat)
   );

   // output register: a waiting result holds the back end, while the queue
   // keeps taking summaries from the front
   edbp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .stat        (stat),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

@@ sv/edbp_checker.sv @@
// Port-level checks for the EDID base block parser, bound to the top level.
// Depends on edbp_pkg and edid_base_block_parser_core.
`default_nettype none

module edbp_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire edbp_pkg::rsp_type rsp_payload
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // an error is always a run of one item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != edbp_pkg::STATUS_OK |-> rsp_payload.last_of_run)
      else $error("error result not alone in its run");

   // an error carries no name
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != edbp_pkg::STATUS_OK
      |-> rsp_payload.name_char == 7'd0 && rsp_payload.name_length == 4'd0
          && rsp_payload.letter_first == 7'd0)
      else $error("error result carries name data");

   // a good name is non-empty and printable
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == edbp_pkg::STATUS_OK
      |-> rsp_payload.name_length != 4'd0 && rsp_payload.name_char >= 7'h20
          && rsp_payload.name_char != 7'h7F)
      else $error("bad name character");

   // header or ID failure clears the manufacturer ID
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == edbp_pkg::STATUS_BAD_HEADER
                    || rsp_payload.status == edbp_pkg::STATUS_ID_TRUNCATED)
      |-> rsp_payload.manufacturer_id == 16'd0)
      else $error("manufacturer ID not cleared");

endmodule

bind edid_base_block_parser_core edbp_checker u_edbp_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
